@@ src/fdx_pkg.sv @@
package fdx_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned FieldW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HdrBytes = 6;
  localparam logic [ByteW-1:0] SofReset = 8'hAA;
  localparam int unsigned OutDataW = 64;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_HCHK,
    PH_PAYLOAD,
    PH_DCHK
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_HEAD_ERR = 2'd1,
    ST_DATA_ERR = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             frame_start;
    logic             buffer_end;
  } in_item_t;

  typedef struct packed {
    kind_e             out_kind;
    logic [ByteW-1:0]  payload_byte;
    logic [FieldW-1:0] frame_id;
    logic [FieldW-1:0] frame_type;
    logic [FieldW-1:0] frame_len;
    status_e           status;
    logic              payload_last;
  } res_item_t;

endpackage

@@ src/fdx_in_stage.sv @@
module fdx_in_stage
  import fdx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     advance_i,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on every transfer.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/fdx_parser.sv @@
module fdx_parser
  import fdx_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  in_item_t         item_i,
  input  logic [ByteW-1:0] sof_value_i,
  output logic             res_valid_o,
  output res_item_t        res_o
);

  phase_e            phase_q, phase_d;
  logic [FieldW-1:0] idx_q, idx_d;
  logic [FieldW-1:0] id_q, id_d;
  logic [FieldW-1:0] len_q, len_d;
  logic [FieldW-1:0] type_q, type_d;
  logic [ByteW-1:0]  head_acc_q, head_acc_d;
  logic [ByteW-1:0]  data_acc_q, data_acc_d;

  logic [FieldW-1:0] idx_inc;
  logic [ByteW-1:0]  head_x;
  logic [ByteW-1:0]  data_x;
  logic              hchk_ok;
  logic              dchk_ok;
  logic              pay_last;

  assign idx_inc  = idx_q + FieldW'(1);
  assign head_x   = head_acc_q ^ item_i.in_byte;
  assign data_x   = data_acc_q ^ item_i.in_byte;
  assign hchk_ok  = (item_i.in_byte == ~head_acc_q);
  assign dchk_ok  = (item_i.in_byte == ~data_acc_q);
  assign pay_last = (idx_inc >= len_q);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      if (item_i.frame_start) begin
        phase_d = item_i.buffer_end ? PH_IDLE : PH_HEADER;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (item_i.buffer_end) begin
              phase_d = PH_IDLE;
            end else if (idx_inc >= FieldW'(HdrBytes)) begin
              phase_d = PH_HCHK;
            end
          end
          PH_HCHK: begin
            if (!hchk_ok || item_i.buffer_end) begin
              phase_d = PH_IDLE;
            end else begin
              phase_d = (len_q == '0) ? PH_DCHK : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (item_i.buffer_end) begin
              phase_d = PH_IDLE;
            end else if (pay_last) begin
              phase_d = PH_DCHK;
            end
          end
          PH_DCHK: phase_d = PH_IDLE;
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Field capture, check accumulators and the result.
  always_comb begin
    idx_d      = idx_q;
    id_d       = id_q;
    len_d      = len_q;
    type_d     = type_q;
    head_acc_d = head_acc_q;
    data_acc_d = data_acc_q;
    res_valid_o        = 1'b0;
    res_o.out_kind     = KIND_STATUS;
    res_o.payload_byte = '0;
    res_o.status       = ST_OK;
    res_o.payload_last = 1'b0;
    if (step_i) begin
      if (item_i.frame_start) begin
        idx_d      = '0;
        id_d       = '0;
        len_d      = '0;
        type_d     = '0;
        head_acc_d = sof_value_i;
        data_acc_d = '0;
        if (item_i.buffer_end) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_TRUNC;
        end
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            idx_d      = idx_inc;
            head_acc_d = head_x;
            // Big-endian fields, high byte first.
            case (idx_inc)
              FieldW'(1): id_d   = {item_i.in_byte, id_q[ByteW-1:0]};
              FieldW'(2): id_d   = {id_q[FieldW-1:ByteW], item_i.in_byte};
              FieldW'(3): len_d  = {item_i.in_byte, len_q[ByteW-1:0]};
              FieldW'(4): len_d  = {len_q[FieldW-1:ByteW], item_i.in_byte};
              FieldW'(5): type_d = {item_i.in_byte, type_q[ByteW-1:0]};
              default:    type_d = {type_q[FieldW-1:ByteW], item_i.in_byte};
            endcase
            if (item_i.buffer_end) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_TRUNC;
            end
          end
          PH_HCHK: begin
            if (!hchk_ok) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_HEAD_ERR;
            end else begin
              idx_d = '0;
              if (item_i.buffer_end) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_TRUNC;
              end
            end
          end
          PH_PAYLOAD: begin
            data_acc_d  = data_x;
            idx_d       = idx_inc;
            res_valid_o = 1'b1;
            if (item_i.buffer_end) begin
              res_o.status = ST_TRUNC;
            end else begin
              res_o.out_kind     = KIND_PAYLOAD;
              res_o.payload_byte = item_i.in_byte;
              res_o.payload_last = pay_last;
            end
          end
          PH_DCHK: begin
            res_valid_o  = 1'b1;
            res_o.status = dchk_ok ? ST_OK : ST_DATA_ERR;
          end
          default: ;
        endcase
      end
    end
    res_o.frame_id   = id_d;
    res_o.frame_type = type_d;
    res_o.frame_len  = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      idx_q      <= '0;
      id_q       <= '0;
      len_q      <= '0;
      type_q     <= '0;
      head_acc_q <= '0;
      data_acc_q <= '0;
    end else begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      id_q       <= id_d;
      len_q      <= len_d;
      type_q     <= type_d;
      head_acc_q <= head_acc_d;
      data_acc_q <= data_acc_d;
    end
  end

endmodule

@@ src/fdx_out_reg.sv @@
module fdx_out_reg
  import fdx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_item_t item_i,
  output logic      ready_o,
  output logic      valid_o,
  input  logic      ready_i,
  output res_item_t item_o
);

  logic      valid_q, valid_d;
  res_item_t item_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/frame_deframer_xor_check_top.sv @@
// Channel    | Direction | tdata (low bit up)                  | tuser       | tlast
// s_axis     | in        | in_byte[7:0]                        | frame_start | buffer_end
// m_axis     | out       | payload_byte, frame_id, frame_type, | out_kind    | payload_last
//            |           | frame_len, status, zero pad to 64   |             |
// cfg        | in        | sof_value[7:0] written on cfg_we_i  | -           | -
//
// One byte per cycle sustained while m_axis does not stall: a byte lands in the input
// register, the parser resolves it combinationally and places at most one result in the output register.
// After its input transfer a byte is held in the input register, and its result
// in the output register, from which the result transfers on m_axis.
// Reset clears all control and parser state and sets sof_value to 0xAA.
// A stall on m_axis holds the output register; the parser and input register
// advance only while the output register is empty or being drained.
module frame_deframer_xor_check_top
  import fdx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Stream in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,  // [7:0] in_byte
  input  logic                s_axis_tuser_i,  // frame_start
  input  logic                s_axis_tlast_i,  // buffer_end
  // Stream out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] payload_byte, [23:8] frame_id, [39:24] frame_type,
  // [55:40] frame_len, [57:56] status, [63:58] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tuser_o,  // out_kind
  output logic                m_axis_tlast_o,  // payload_last
  // Configuration
  input  logic                cfg_we_i,
  input  logic [ByteW-1:0]    cfg_wdata_i      // sof_value
);

  localparam int unsigned PackW = ByteW + 3 * FieldW + StatusW;

  logic [ByteW-1:0] sof_q;

  in_item_t  in_item;
  in_item_t  stage_item;
  logic      stage_valid;
  logic      out_ready;
  logic      step;
  logic      res_valid;
  res_item_t res;
  res_item_t out_item;

  // Start value register; the parser samples it on each start byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_q <= SofReset;
    end else if (cfg_we_i) begin
      sof_q <= cfg_wdata_i;
    end
  end

  assign in_item.in_byte     = s_axis_tdata_i;
  assign in_item.frame_start = s_axis_tuser_i;
  assign in_item.buffer_end  = s_axis_tlast_i;

  // Advance the staged byte whenever the output register can take a result.
  assign step = stage_valid && out_ready;

  fdx_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (stage_valid),
    .advance_i (step),
    .item_o    (stage_item)
  );

  fdx_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (stage_item),
    .sof_value_i (sof_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fdx_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .item_i  (res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .item_o  (out_item)
  );

  // Pack result fields, first field in the lowest bits.
  assign m_axis_tdata_o = {{(OutDataW - PackW){1'b0}},
                           out_item.status,
                           out_item.frame_len,
                           out_item.frame_type,
                           out_item.frame_id,
                           out_item.payload_byte};
  assign m_axis_tuser_o = out_item.out_kind;
  assign m_axis_tlast_o = out_item.payload_last;

endmodule

@@ sim/fdx_stream_checker.sv @@
module fdx_stream_checker
  import fdx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [ByteW-1:0]    s_axis_tdata_i,
  input  logic                s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  input  logic                m_axis_tuser_i,
  input  logic                m_axis_tlast_i,
  input  logic                cfg_we_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int unsigned IdLo   = ByteW;
  localparam int unsigned TypeLo = IdLo + FieldW;
  localparam int unsigned LenLo  = TypeLo + FieldW;
  localparam int unsigned StLo   = LenLo + FieldW;
  localparam int unsigned PadLo  = StLo + StatusW;

  // Parser state, mirrored at the block's widths
  phase_e            phase_q;
  logic [FieldW-1:0] idx_q;
  logic [FieldW-1:0] id_q;
  logic [FieldW-1:0] len_q;
  logic [FieldW-1:0] type_q;
  logic [ByteW-1:0]  hsum_q;
  logic [ByteW-1:0]  dsum_q;
  logic [ByteW-1:0]  sof_q;

  res_item_t frame_results_q[$];

  function automatic res_item_t make_result(kind_e kind, logic [ByteW-1:0] pbyte,
                                            status_e st, logic last);
    res_item_t r;
    r.out_kind     = kind;
    r.payload_byte = pbyte;
    r.frame_id     = id_q;
    r.frame_type   = type_q;
    r.frame_len    = len_q;
    r.status       = st;
    r.payload_last = last;
    return r;
  endfunction

  task automatic close_frame(status_e st);
    phase_q = PH_IDLE;
    frame_results_q.push_back(make_result(KIND_STATUS, '0, st, 1'b0));
  endtask

  task automatic deframe_byte(logic [ByteW-1:0] b, logic sof, logic eob);
    logic last;
    if (sof) begin
      phase_q = PH_HEADER;
      idx_q   = '0;
      id_q    = '0;
      len_q   = '0;
      type_q  = '0;
      hsum_q  = sof_q;
      dsum_q  = '0;
      if (eob) close_frame(ST_TRUNC);
    end else begin
      case (phase_q)
        PH_HEADER: begin
          idx_q  = idx_q + 1'b1;
          hsum_q = hsum_q ^ b;
          // big-endian header: id, length, type
          case (idx_q)
            1: id_q[15:8]   = b;
            2: id_q[7:0]    = b;
            3: len_q[15:8]  = b;
            4: len_q[7:0]   = b;
            5: type_q[15:8] = b;
            default: type_q[7:0] = b;
          endcase
          if (idx_q >= HdrBytes) phase_q = PH_HCHK;
          if (eob) close_frame(ST_TRUNC);
        end
        PH_HCHK: begin
          if (b != ~hsum_q) begin
            close_frame(ST_HEAD_ERR);
          end else begin
            idx_q   = '0;
            phase_q = (len_q == 0) ? PH_DCHK : PH_PAYLOAD;
            if (eob) close_frame(ST_TRUNC);
          end
        end
        PH_PAYLOAD: begin
          dsum_q = dsum_q ^ b;
          idx_q  = idx_q + 1'b1;
          last   = (idx_q >= len_q);
          if (last) phase_q = PH_DCHK;
          // a payload byte on buffer end is dropped in favor of the status
          if (eob) close_frame(ST_TRUNC);
          else frame_results_q.push_back(make_result(KIND_PAYLOAD, b, ST_OK, last));
        end
        PH_DCHK: begin
          close_frame((b == ~dsum_q) ? ST_OK : ST_DATA_ERR);
        end
        default: ;
      endcase
    end
  endtask

  function automatic void check_field(string name, logic [FieldW-1:0] want,
                                      logic [FieldW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  task automatic check_result();
    res_item_t want;
    if (frame_results_q.size() == 0) begin
      $error("result transfer with no result pending: tdata 0x%0h tuser %0b",
             m_axis_tdata_i, m_axis_tuser_i);
      fail_count_o++;
    end else begin
      want = frame_results_q.pop_front();
      check_field("out_kind", want.out_kind, m_axis_tuser_i);
      check_field("payload_byte", want.payload_byte, m_axis_tdata_i[ByteW-1:0]);
      check_field("frame_id", want.frame_id, m_axis_tdata_i[IdLo +: FieldW]);
      check_field("frame_type", want.frame_type, m_axis_tdata_i[TypeLo +: FieldW]);
      check_field("frame_len", want.frame_len, m_axis_tdata_i[LenLo +: FieldW]);
      check_field("status", want.status, m_axis_tdata_i[StLo +: StatusW]);
      check_field("pad", '0, m_axis_tdata_i[OutDataW-1:PadLo]);
      check_field("payload_last", want.payload_last, m_axis_tlast_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q = PH_IDLE;
      idx_q   = '0;
      id_q    = '0;
      len_q   = '0;
      type_q  = '0;
      hsum_q  = '0;
      dsum_q  = '0;
      sof_q   = SofReset;
      frame_results_q.delete();
      fail_count_o = 0;
    end else begin
      // results leaving now stem from older bytes: compare before predicting
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (s_axis_tvalid_i && s_axis_tready_i)
        deframe_byte(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      if (cfg_we_i) sof_q = cfg_wdata_i;
    end
    pending_o = frame_results_q.size();
  end

endmodule

@@ sim/tb.sv @@
module tb;
  import fdx_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 8;
  // Bytes of frame traffic in the randomized part, and per register setting
  localparam int RandomBytes = 1850;
  localparam int PhaseBytes  = 240;
  // Worst case has both sides stalling at their longest; keep a wide
  // margin over that
  localparam int CycleLimit  = 500000;
  // Cycles to wait past the last result: pipeline drain plus slack
  localparam int SettleCycles = 6;
  localparam int MaxWait      = 13;

  logic                clk;
  logic                rst_n;
  logic                s_valid;
  logic                s_ready;
  logic [ByteW-1:0]    s_data;
  logic                s_user;
  logic                s_last;
  logic                m_valid;
  logic                m_ready;
  logic [OutDataW-1:0] m_data;
  logic                m_user;
  logic                m_last;
  logic                cfg_we;
  logic [ByteW-1:0]    cfg_wdata;

  int fail_count;
  int pending;
  int cycles;
  int ready_wait;
  bit quiet;                    // suppress idling on both sides
  logic [ByteW-1:0] cur_sof;    // register value as last written
  in_item_t buffer_q[$];        // bytes of the receive buffer still to send

  frame_deframer_xor_check_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  fdx_stream_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .m_axis_tlast_i  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial clk = 1'b0;
  always #HalfPeriod clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: after each result transfer, draw a stall and hold tready low
  // for that many cycles, then raise it again
  always @(negedge clk) begin
    if (ready_wait > 0) begin
      m_ready    <= 1'b0;
      ready_wait <= ready_wait - 1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (m_valid && m_ready) ready_wait <= quiet ? 0 : $urandom_range(0, MaxWait);
  end

  // Drive one byte: idle for a random gap, present it, hold until the transfer.
  // Called and returns at a falling edge.
  task automatic send_byte(in_item_t item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      if (s_valid) s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= item.in_byte;
    s_user  <= item.frame_start;
    s_last  <= item.buffer_end;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    while (buffer_q.size() > 0) send_byte(buffer_q.pop_front());
  endtask

  // Build one frame into the buffer. keep cuts it after that many bytes
  // (start byte included); buffer_end goes on the last byte kept.
  task automatic add_frame(logic [15:0] id, logic [15:0] len, logic [15:0] typ,
                           bit bad_hdr, bit bad_data, int keep, bit end_flag);
    logic [ByteW-1:0] hdr [6];
    logic [ByteW-1:0] frame_q[$];
    logic [ByteW-1:0] hsum;
    logic [ByteW-1:0] dsum;
    logic [ByteW-1:0] flip;
    int n;
    hdr = '{id[15:8], id[7:0], len[15:8], len[7:0], typ[15:8], typ[7:0]};
    frame_q.push_back(8'($urandom));      // start byte: any value
    hsum = cur_sof;
    foreach (hdr[i]) begin
      frame_q.push_back(hdr[i]);
      hsum ^= hdr[i];
    end
    flip = bad_hdr ? 8'($urandom_range(1, 255)) : 8'h00;
    frame_q.push_back(~hsum ^ flip);
    if (!bad_hdr) begin
      dsum = '0;
      // stop early on long frames that get cut anyway
      for (n = 0; n < len && frame_q.size() < keep; n++) begin
        frame_q.push_back(8'($urandom));
        dsum ^= frame_q[$];
      end
      flip = bad_data ? 8'($urandom_range(1, 255)) : 8'h00;
      frame_q.push_back(~dsum ^ flip);
    end
    while (frame_q.size() > keep) void'(frame_q.pop_back());
    foreach (frame_q[i])
      buffer_q.push_back('{in_byte: frame_q[i], frame_start: (i == 0),
                           buffer_end: end_flag && (i == frame_q.size() - 1)});
  endtask

  // Unstructured bytes with random markers
  task automatic add_noise(int count);
    repeat (count)
      buffer_q.push_back('{in_byte: 8'($urandom),
                           frame_start: ($urandom_range(0, 7) == 0),
                           buffer_end: ($urandom_range(0, 3) == 0)});
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 16'($urandom_range(0, 8));
    if (r < 19) return 16'($urandom_range(9, 40));
    return 16'($urandom_range(41, 200));
  endfunction

  task automatic add_random_frame();
    int pick;
    int total;
    logic [15:0] len;
    pick  = $urandom_range(0, 99);
    len   = pick_len();
    total = int'(len) + 9;
    if (pick < 55) begin
      add_frame(16'($urandom), len, 16'($urandom), 1'b0, 1'b0, total,
                1'($urandom_range(0, 1)));
    end else if (pick < 65) begin
      add_frame(16'($urandom), len, 16'($urandom), 1'b0, 1'b1, total,
                1'($urandom_range(0, 1)));
    end else if (pick < 73) begin
      // bad header check with any length; nothing past the check byte
      add_frame(16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b0, 8,
                1'($urandom_range(0, 1)));
    end else if (pick < 84) begin
      // buffer ends early, often on a frame that claims a huge length
      if ($urandom_range(0, 1)) len = 16'($urandom);
      total = int'(len) + 9;
      add_frame(16'($urandom), len, 16'($urandom), 1'b0, 1'b0,
                $urandom_range(1, (total - 1 < 24) ? total - 1 : 24), 1'b1);
    end else if (pick < 92) begin
      // cut short with no buffer end: the next start byte abandons it
      add_frame(16'($urandom), len, 16'($urandom), 1'b0, 1'b0,
                $urandom_range(1, total - 1), 1'b0);
    end else begin
      add_noise($urandom_range(1, 6));
    end
  endtask

  // Drain the block, then write the register while it is idle
  task automatic write_sof(logic [ByteW-1:0] value);
    if (s_valid) s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_sof  = value;
  endtask

  initial begin
    int total_bytes;
    int phase_bytes;
    int phase_no;
    rst_n      = 1'b0;
    s_valid    = 1'b0;
    s_data     = '0;
    s_user     = 1'b0;
    s_last     = 1'b0;
    m_ready    = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    cycles     = 0;
    ready_wait = 0;
    quiet      = 1'b0;
    cur_sof    = SofReset;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, under the reset value of the register.
    // A stray byte before any frame: ignored.
    buffer_q.push_back('{in_byte: 8'h5A, frame_start: 1'b0, buffer_end: 1'b0});
    // Zero length, extreme header fields, buffer end on the data check byte
    add_frame(16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 9, 1'b1);
    // Bad header check that is also the last byte of the buffer
    add_frame(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 8, 1'b1);
    // Start byte that is also the buffer end
    add_frame(16'h1234, 16'h0001, 16'h00FF, 1'b0, 1'b0, 1, 1'b1);
    // Restart mid-header, then a buffer that ends on a payload byte
    add_frame(16'hA5A5, 16'h0002, 16'h5A5A, 1'b0, 1'b0, 3, 1'b0);
    add_frame(16'h00FF, 16'h0002, 16'hFF00, 1'b0, 1'b0, 10, 1'b1);
    send_buffer();

    // Randomized part: one register setting per stretch, extremes first
    total_bytes = 0;
    phase_no    = 0;
    while (total_bytes < RandomBytes) begin
      case (phase_no)
        0: write_sof(8'h00);
        1: write_sof(8'hFF);
        default: write_sof(8'($urandom));
      endcase
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes && total_bytes < RandomBytes) begin
        quiet = ($urandom_range(0, 7) == 0);
        add_random_frame();
        phase_bytes += buffer_q.size();
        total_bytes += buffer_q.size();
        // trailing bytes without a start marker; mostly ignored, not counted
        if ($urandom_range(0, 5) == 0) add_noise(0);
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3))
            buffer_q.push_back('{in_byte: 8'($urandom), frame_start: 1'b0,
                                 buffer_end: 1'($urandom_range(0, 1))});
        send_buffer();
      end
      phase_no++;
    end

    // Drain and let the pipeline settle before the verdict
    quiet = 1'b0;
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/fdx_pkg.sv
src/fdx_in_stage.sv
src/fdx_parser.sv
src/fdx_out_reg.sv
src/frame_deframer_xor_check_top.sv
sim/fdx_stream_checker.sv
sim/tb.sv
